/* rtl/utd_pkg.sv */
package utd_pkg;

   localparam int COUNT_BITS_DEFAULT = 16;
   localparam logic [15:0] CAPACITY_RESET = 16'hFFFF;

   localparam logic [20:0] MAX_CODE  = 21'h10FFFF;
   localparam logic [20:0] BMP_MAX   = 21'h00FFFF;
   localparam logic [20:0] SUPP_BASE = 21'h010000;
   localparam logic [15:0] SURR_HIGH = 16'hD800;
   localparam logic [15:0] SURR_LOW  = 16'hDC00;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_OVERFLOW = 2'd1,
      STATUS_INVALID  = 2'd2
   } status_type;

   typedef enum logic {
      KIND_UNIT    = 1'b0,
      KIND_SUMMARY = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] code_unit;
      status_type  status;
      logic [15:0] unit_count;
      logic        last;
   } result_type;

   // up to two code units plus an end-of-string summary per byte
   typedef struct packed {
      logic [1:0]            count;
      result_type [2:0]      items;
   } bundle_type;

   function automatic logic [6:0] lead_mask(input logic [1:0] len);
      logic [6:0] m;
      case (len)
         2'd0:    m = 7'h7F;
         2'd1:    m = 7'h1F;
         2'd2:    m = 7'h0F;
         2'd3:    m = 7'h07;
         default: m = 7'h7F;
      endcase
      return m;
   endfunction

   function automatic logic [20:0] min_value(input logic [1:0] len);
      logic [20:0] m;
      case (len)
         2'd0:    m = 21'h000000;
         2'd1:    m = 21'h000080;
         2'd2:    m = 21'h000800;
         2'd3:    m = 21'h010000;
         default: m = 21'h000000;
      endcase
      return m;
   endfunction

endpackage

/* rtl/utd_decode.sv */
module utd_decode #(
   parameter int COUNT_BITS = utd_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_in_byte,
   input  logic                req_in_last,
   input  logic [15:0]         out_capacity,
   input  logic                room,
   output logic                push,
   output utd_pkg::bundle_type bundle
);
   import utd_pkg::*;

   localparam logic [32:0] COUNT_MAX = (33'd1 << COUNT_BITS) - 33'd1;

   // input register
   logic       stage_valid_ff, stage_valid_in;
   logic [7:0] byte_ff;
   logic       last_ff;

   // per-string state
   logic [1:0]            pend_ff, pend_in;
   logic [1:0]            slen_ff, slen_in;
   logic [20:0]           acc_ff, acc_in;
   logic [COUNT_BITS-1:0] units_ff, units_in;
   status_type            outcome_ff, outcome_in;

   logic                  accept, advance;
   logic [32:0]           cap_ext, lim_ext;
   logic [COUNT_BITS-1:0] limit;
   logic [COUNT_BITS:0]   units_p1;
   logic [1:0]            lead_len;
   logic [20:0]           acc_shift;
   logic [19:0]           supp;
   logic [1:0]            nu;
   logic [15:0]           u0, u1;
   logic [COUNT_BITS-1:0] cnt1, cnt2;
   logic [32:0]           cnt1_ext, cnt2_ext, total_ext;
   result_type            unit0, unit1, summ;

   assign advance        = stage_valid_ff && room;
   assign req_stall      = stage_valid_ff && !room;
   assign accept         = req_valid && !req_stall;
   assign stage_valid_in = accept ? 1'b1 : (advance ? 1'b0 : stage_valid_ff);
   assign push           = advance;

   // effective limit: smaller of the register and the counter range
   assign cap_ext = {17'd0, out_capacity};
   assign lim_ext = (cap_ext < COUNT_MAX) ? cap_ext : COUNT_MAX;
   assign limit   = lim_ext[COUNT_BITS-1:0];

   assign units_p1  = {1'b0, units_ff} + {{COUNT_BITS{1'b0}}, 1'b1};
   assign acc_shift = {acc_ff[14:0], byte_ff[5:0]};
   assign supp      = 20'(acc_shift - SUPP_BASE);

   always_comb begin
      if (byte_ff >= 8'hC2 && byte_ff <= 8'hDF) begin
         lead_len = 2'd1;
      end else if (byte_ff >= 8'hE0 && byte_ff <= 8'hEF) begin
         lead_len = 2'd2;
      end else if (byte_ff >= 8'hF0 && byte_ff <= 8'hF4) begin
         lead_len = 2'd3;
      end else begin
         lead_len = 2'd0;
      end
   end

   // next state and emitted units
   always_comb begin
      pend_in    = pend_ff;
      slen_in    = slen_ff;
      acc_in     = acc_ff;
      outcome_in = outcome_ff;
      nu         = 2'd0;
      u0         = 16'd0;
      u1         = 16'd0;
      if (outcome_ff == STATUS_OK) begin
         if (pend_ff == 2'd0) begin
            if (units_ff >= limit) begin
               outcome_in = STATUS_OVERFLOW;
            end else if (!byte_ff[7]) begin
               nu = 2'd1;
               u0 = {8'd0, byte_ff};
            end else if (lead_len == 2'd0) begin
               outcome_in = STATUS_INVALID;
            end else begin
               slen_in = lead_len;
               pend_in = lead_len;
               acc_in  = {14'd0, byte_ff[6:0] & lead_mask(lead_len)};
            end
         end else if (byte_ff[7:6] != 2'b10) begin
            outcome_in = STATUS_INVALID;
         end else begin
            acc_in  = acc_shift;
            pend_in = pend_ff - 2'd1;
            if (pend_in == 2'd0) begin
               if (acc_shift < min_value(slen_ff) || acc_shift > MAX_CODE) begin
                  outcome_in = STATUS_INVALID;
               end else if (acc_shift <= BMP_MAX) begin
                  nu = 2'd1;
                  u0 = acc_shift[15:0];
               end else if (units_p1 >= {1'b0, limit}) begin
                  outcome_in = STATUS_OVERFLOW;
               end else begin
                  nu = 2'd2;
                  u0 = SURR_HIGH | {6'd0, supp[19:10]};
                  u1 = SURR_LOW | {6'd0, supp[9:0]};
               end
               slen_in = 2'd0;
               acc_in  = 21'd0;
            end
         end
         // string ends inside a sequence
         if (last_ff && outcome_in == STATUS_OK && pend_in != 2'd0) begin
            outcome_in = STATUS_INVALID;
         end
      end
   end

   assign units_in  = units_ff + COUNT_BITS'(nu);
   assign cnt1      = units_p1[COUNT_BITS-1:0];
   assign cnt2      = units_ff + COUNT_BITS'(2);
   assign cnt1_ext  = 33'(cnt1);
   assign cnt2_ext  = 33'(cnt2);
   assign total_ext = 33'(units_in);

   always_comb begin
      unit0 = '{kind: KIND_UNIT, code_unit: u0, status: STATUS_OK,
                unit_count: cnt1_ext[15:0], last: 1'b0};
      unit1 = '{kind: KIND_UNIT, code_unit: u1, status: STATUS_OK,
                unit_count: cnt2_ext[15:0], last: 1'b0};
      summ  = '{kind: KIND_SUMMARY, code_unit: 16'd0, status: outcome_in,
                unit_count: total_ext[15:0], last: 1'b1};
      bundle = '0;
      case (nu)
         2'd0: begin
            bundle.items[0] = summ;
            bundle.count    = {1'b0, last_ff};
         end
         2'd1: begin
            unit0.last      = !last_ff;
            bundle.items[0] = unit0;
            bundle.items[1] = summ;
            bundle.count    = 2'd1 + {1'b0, last_ff};
         end
         2'd2: begin
            unit1.last      = !last_ff;
            bundle.items[0] = unit0;
            bundle.items[1] = unit1;
            bundle.items[2] = summ;
            bundle.count    = 2'd2 + {1'b0, last_ff};
         end
         default: begin
            bundle = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
      if (accept) begin
         byte_ff <= req_in_byte;
         last_ff <= req_in_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff    <= 2'd0;
         slen_ff    <= 2'd0;
         acc_ff     <= 21'd0;
         units_ff   <= '0;
         outcome_ff <= STATUS_OK;
      end else if (advance) begin
         if (last_ff) begin
            pend_ff    <= 2'd0;
            slen_ff    <= 2'd0;
            acc_ff     <= 21'd0;
            units_ff   <= '0;
            outcome_ff <= STATUS_OK;
         end else begin
            pend_ff    <= pend_in;
            slen_ff    <= slen_in;
            acc_ff     <= acc_in;
            units_ff   <= units_in;
            outcome_ff <= outcome_in;
         end
      end
   end

endmodule

/* rtl/utd_result_queue.sv */
module utd_result_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  utd_pkg::bundle_type bundle,
   output logic                room,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_kind,
   output logic [15:0]         rsp_code_unit,
   output logic [1:0]          rsp_status,
   output logic [15:0]         rsp_unit_count,
   output logic                rsp_last
);
   import utd_pkg::*;

   localparam int DEPTH = 4;

   result_type entry_ff [DEPTH];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] count_ff, count_in;
   logic [1:0] push_count;
   logic       pop;
   result_type head;

   assign push_count = push ? bundle.count : 2'd0;
   assign pop        = rsp_valid && !rsp_stall;
   // a byte may bring three items, so take one only with three free entries
   assign room       = count_ff <= 3'd1;
   assign wr_ptr_in  = wr_ptr_ff + push_count;
   assign rd_ptr_in  = rd_ptr_ff + {1'b0, pop};
   assign count_in   = count_ff + {1'b0, push_count} - {2'd0, pop};

   assign head           = entry_ff[rd_ptr_ff];
   assign rsp_valid      = count_ff != 3'd0;
   assign rsp_kind       = head.kind;
   assign rsp_code_unit  = head.code_unit;
   assign rsp_status     = head.status;
   assign rsp_unit_count = head.unit_count;
   assign rsp_last       = head.last;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 2'd0;
         rd_ptr_ff <= 2'd0;
         count_ff  <= 3'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         if (2'(i) < push_count) begin
            entry_ff[wr_ptr_ff + 2'(i)] <= bundle.items[i];
         end
      end
   end

endmodule

/* rtl/utf8_to_utf16_decoder_unit.sv */
// UTF-8 to UTF-16 decoder. Takes one UTF-8 byte per item on the req_
// channel (req_in_last marks the final byte of a string) and returns UTF-16
// code units on the rsp_ channel, plus one summary item (status, unit count)
// after the final byte. A byte is taken every cycle while the result queue
// has three free entries; results leave at one per cycle while rsp_stall is
// low, so a plain byte stream runs at one byte per cycle and a byte that
// yields a surrogate pair and a summary puts three items in the queue. An
// accepted byte passes the input register and then the result queue before
// its first result shows. csr_wr_data sets the per-string unit capacity;
// write it only while the block is idle.
module utf8_to_utf16_decoder_unit #(
   parameter int COUNT_BITS = utd_pkg::COUNT_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // byte input
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        req_in_last,
   // results
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_kind,
   output logic [15:0] rsp_code_unit,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_unit_count,
   output logic        rsp_last,
   // capacity register
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);
   import utd_pkg::*;

   logic [15:0] capacity_ff;
   logic        push;
   logic        room;
   bundle_type  bundle;

   // capacity register; all-ones gives 65535 units, or the counter range if smaller
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
      end else if (csr_wr_en) begin
         capacity_ff <= csr_wr_data;
      end
   end

   // input register, string state and single-pass decode
   utd_decode #(
      .COUNT_BITS(COUNT_BITS)
   ) u_decode (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_in_byte (req_in_byte),
      .req_in_last (req_in_last),
      .out_capacity(capacity_ff),
      .room        (room),
      .push        (push),
      .bundle      (bundle)
   );

   // four-entry result queue, drained one item per cycle while rsp_stall is low
   utd_result_queue u_queue (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .bundle        (bundle),
      .room          (room),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_kind      (rsp_kind),
      .rsp_code_unit (rsp_code_unit),
      .rsp_status    (rsp_status),
      .rsp_unit_count(rsp_unit_count),
      .rsp_last      (rsp_last)
   );

endmodule

/* verif/tb.sv */
`timescale 1ns / 100ps

module tb;
   import utd_pkg::*;

   // Predicts the UTF-16 items a byte stream should produce and matches the
   // block's output against them in order.
   class utf16_scoreboard;
      logic [15:0] capacity;
      logic [1:0]  conts_left;
      logic [1:0]  seq_len;
      logic [20:0] accum;
      logic [15:0] units;
      status_type  outcome;
      result_type  awaited_results[$];
      result_type  batch[$];
      int unsigned errors;
      int unsigned byte_count;

      function new();
         capacity = CAPACITY_RESET;
         errors = 0;
         byte_count = 0;
         clear_string();
      endfunction

      function void clear_string();
         conts_left = 2'd0;
         seq_len = 2'd0;
         accum = 21'd0;
         units = 16'd0;
         outcome = STATUS_OK;
      endfunction

      function void emit_unit(logic [15:0] unit);
         result_type r;
         units++;
         r.kind = KIND_UNIT;
         r.code_unit = unit;
         r.status = STATUS_OK;
         r.unit_count = units;
         r.last = 1'b0;
         batch.push_back(r);
      endfunction

      // Runs one accepted byte through the decoder and queues what it yields.
      function void decode_byte(logic [7:0] b, logic fin);
         logic [1:0]  len;
         logic [20:0] v;
         logic [20:0] floor_value;
         result_type  summary;
         batch.delete();
         byte_count++;
         if (outcome == STATUS_OK) begin
            if (conts_left == 2'd0) begin
               if (units >= capacity) begin
                  outcome = STATUS_OVERFLOW;
               end else if (b < 8'h80) begin
                  emit_unit({8'h00, b});
               end else begin
                  if (b >= 8'hC2 && b <= 8'hDF) len = 2'd1;
                  else if (b >= 8'hE0 && b <= 8'hEF) len = 2'd2;
                  else if (b >= 8'hF0 && b <= 8'hF4) len = 2'd3;
                  else len = 2'd0;
                  if (len == 2'd0) begin
                     outcome = STATUS_INVALID;
                  end else begin
                     seq_len = len;
                     conts_left = len;
                     accum = 21'(b & (8'h3F >> len));
                  end
               end
            end else if (b[7:6] != 2'b10) begin
               outcome = STATUS_INVALID;
            end else begin
               accum = {accum[14:0], b[5:0]};
               conts_left = conts_left - 2'd1;
               if (conts_left == 2'd0) begin
                  v = accum;
                  floor_value = (seq_len == 2'd1) ? 21'h80 :
                                (seq_len == 2'd2) ? 21'h800 : SUPP_BASE;
                  if (v < floor_value || v > MAX_CODE) begin
                     outcome = STATUS_INVALID;
                  end else if (v <= BMP_MAX) begin
                     emit_unit(v[15:0]);
                  end else if (17'(units) + 17'd1 >= 17'(capacity)) begin
                     outcome = STATUS_OVERFLOW;
                  end else begin
                     v = v - SUPP_BASE;
                     emit_unit(SURR_HIGH | {6'd0, v[19:10]});
                     emit_unit(SURR_LOW | {6'd0, v[9:0]});
                  end
                  seq_len = 2'd0;
                  accum = 21'd0;
               end
            end
            if (fin && outcome == STATUS_OK && conts_left != 2'd0)
               outcome = STATUS_INVALID;
         end
         if (fin) begin
            summary.kind = KIND_SUMMARY;
            summary.code_unit = 16'd0;
            summary.status = outcome;
            summary.unit_count = units;
            summary.last = 1'b1;
            batch.push_back(summary);
            clear_string();
         end else if (batch.size() != 0) begin
            batch[batch.size() - 1].last = 1'b1;
         end
         foreach (batch[i]) awaited_results.push_back(batch[i]);
      endfunction

      function void compare_field(string name, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            errors++;
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         end
      endfunction

      function void match_output(result_type got);
         result_type want;
         if (awaited_results.size() == 0) begin
            errors++;
            $error("unexpected result: kind %0d code_unit 0x%0h status %0d",
                   got.kind, got.code_unit, got.status);
            return;
         end
         want = awaited_results.pop_front();
         compare_field("kind", 16'(want.kind), 16'(got.kind));
         compare_field("code_unit", want.code_unit, got.code_unit);
         compare_field("status", 16'(want.status), 16'(got.status));
         compare_field("unit_count", want.unit_count, got.unit_count);
         compare_field("last", 16'(want.last), 16'(got.last));
      endfunction

      function int unsigned outstanding();
         return awaited_results.size();
      endfunction
   endclass

   localparam int QUIET_LIMIT      = 2000;  // cycles with no item moving on either side
   localparam int LONG_HOLD_CYCLES = 150;
   localparam int DRAIN_CYCLES     = 6;     // margin after the last awaited item, for a byte that yields nothing
   localparam int PHASE_BYTES      = 62;    // least number of accepted bytes per random phase
   localparam int NUM_PHASES       = 7;

   // capacity per random phase; tiny values hit the overflow paths often
   localparam logic [15:0] PHASE_CAPACITY [NUM_PHASES] =
      '{16'd0, 16'd1, 16'd3, 16'd2, 16'hFFFF, 16'd9, 16'd40000};

   // opening strings, bit 8 marks the final byte of a string
   localparam logic [8:0] OPENING_BYTES [27] = '{
      // ASCII extremes, largest 2-, 3- and 4-byte characters
      9'h000, 9'h07F, 9'h0DF, 9'h0BF, 9'h0EF, 9'h0BF, 9'h0BF,
      9'h0F4, 9'h08F, 9'h0BF, 9'h1BF,
      // overlong lead, then a byte dropped after the error
      9'h0C0, 9'h1FF,
      // overlong 3-byte form
      9'h0E0, 9'h080, 9'h180,
      // above 10FFFF
      9'h0F4, 9'h090, 9'h080, 9'h180,
      // string ends inside a character
      9'h0E2, 9'h182,
      // encoded surrogate goes through as is
      9'h0ED, 9'h0BF, 9'h1BF,
      // lead followed by a non-continuation
      9'h0C2, 9'h141
   };

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_in_byte = 8'h00;
   logic        req_in_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_kind;
   logic [15:0] rsp_code_unit;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_unit_count;
   logic        rsp_last;
   logic        csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = CAPACITY_RESET;

   int unsigned send_idle_pct = 32;
   int unsigned recv_idle_pct = 79;
   bit          hold_armed = 1'b0;
   bit          hold_done = 1'b0;
   int unsigned quiet_cycles = 0;

   utf16_scoreboard sb = new();

   utf8_to_utf16_decoder_unit i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_in_byte    (req_in_byte),
      .req_in_last    (req_in_last),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_code_unit  (rsp_code_unit),
      .rsp_status     (rsp_status),
      .rsp_unit_count (rsp_unit_count),
      .rsp_last       (rsp_last),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Monitor: everything is sampled right at the rising edge, before any
   // nonblocking update of that edge lands, so it sees what the block saw.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            sb.decode_byte(req_in_byte, req_in_last);
         if (rsp_valid && !rsp_stall)
            sb.match_output(result_type'({rsp_kind, rsp_code_unit, rsp_status,
                                          rsp_unit_count, rsp_last}));
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("utf8_to_utf16_decoder_unit regression: fail");
            $finish;
         end
      end
   end

   // Receiver: random stall, plus one long hold-off once armed so the
   // result queue fills and the block has to stall its byte input.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_armed && !hold_done) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Offers one byte, with random gaps first; returns at the edge it is taken.
   task automatic drive_byte(input logic [7:0] value, input logic fin);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_in_byte <= value;
      req_in_last <= fin;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Drops valid, waits so the monitor has logged the last byte,
   // lets every awaited item come out, then covers the latency of a byte
   // that yields nothing.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [15:0] value);
      wait_idle();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.capacity = value;
   endtask

   function automatic logic [20:0] random_code_point(input int len);
      case (len)
         1: return 21'($urandom_range(8'h7F));
         2: return 21'($urandom_range(11'h7FF, 8'h80));
         3: if ($urandom_range(9) == 0)
               return 21'($urandom_range(16'hDFFF, 16'hD800));
            else
               return 21'($urandom_range(16'hFFFF, 12'h800));
         default: return 21'($urandom_range(21'h10FFFF, 21'h10000));
      endcase
   endfunction

   // Plain UTF-8 encoding at a forced length, so overlong forms come out too.
   function automatic void encode_utf8(ref logic [7:0] seq[$], input logic [20:0] cp,
                                       input int len);
      logic [7:0] prefix;
      logic [7:0] body;
      if (len == 1) begin
         seq.push_back({1'b0, cp[6:0]});
      end else begin
         prefix = ~(8'hFF >> len);
         body = 8'(cp >> (6 * (len - 1))) & (8'h7F >> len);
         seq.push_back(prefix | body);
         for (int k = len - 2; k >= 0; k--) seq.push_back({2'b10, 6'(cp >> (6 * k))});
      end
   endfunction

   // Mostly well-formed characters; the rest is noise and broken forms.
   function automatic void append_char(ref logic [7:0] seq[$], ref bit truncated);
      int unsigned pick;
      int          len;
      logic [7:0]  bad;
      pick = $urandom_range(99);
      len = $urandom_range(4, 2);
      if (pick < 82) begin
         len = $urandom_range(4, 1);
         encode_utf8(seq, random_code_point(len), len);
      end else if (pick < 86) begin
         seq.push_back(8'($urandom_range(255)));
      end else if (pick < 90) begin
         // one continuation replaced by something else
         encode_utf8(seq, random_code_point(len), len);
         bad = 8'($urandom_range(255));
         if (bad[7:6] == 2'b10) bad[7] = 1'b0;
         seq[seq.size() - 1 - $urandom_range(len - 2)] = bad;
      end else if (pick < 94) begin
         encode_utf8(seq, 21'($urandom_range(len == 2 ? 16'h7F :
                                             len == 3 ? 16'h7FF : 16'hFFFF)), len);
      end else if (pick < 97) begin
         encode_utf8(seq, 21'($urandom_range(21'h1FFFFF, 21'h110000)), 4);
      end else begin
         // string ends inside this character
         encode_utf8(seq, random_code_point(len), len);
         repeat ($urandom_range(len - 1, 1)) void'(seq.pop_back());
         truncated = 1'b1;
      end
   endfunction

   task automatic send_string(input int max_chars);
      logic [7:0] seq[$];
      bit         truncated;
      int         chars;
      truncated = 1'b0;
      chars = $urandom_range(max_chars, 1);
      for (int i = 0; i < chars && !truncated; i++) append_char(seq, truncated);
      foreach (seq[i]) drive_byte(seq[i], i == seq.size() - 1);
   endtask

   initial begin : stimulus
      int unsigned phase_start;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed strings at the reset capacity
      foreach (OPENING_BYTES[i]) drive_byte(OPENING_BYTES[i][7:0], OPENING_BYTES[i][8]);

      for (int p = 0; p < NUM_PHASES; p++) begin
         write_capacity(PHASE_CAPACITY[p]);
         // idle mix: sender light / receiver heavy, then swapped, then none
         if (p == 2) begin
            send_idle_pct <= 79;
            recv_idle_pct <= 32;
         end
         if (p == 4) begin
            send_idle_pct <= 0;
            recv_idle_pct <= 0;
            hold_armed <= 1'b1;
         end
         phase_start = sb.byte_count;
         // every accepted byte counts, dropped tails included
         while (sb.byte_count - phase_start < PHASE_BYTES)
            send_string(PHASE_CAPACITY[p] < 16 ? 4 : 12);
      end

      wait_idle();
      if (sb.errors == 0)
         $display("utf8_to_utf16_decoder_unit regression: pass");
      else
         $display("utf8_to_utf16_decoder_unit regression: fail");
      $finish;
   end

endmodule
